// File: src/pra_pkg.sv
// pra_pkg: shared types, codes and constants of the palette region allocator.
// No dependencies; used by pra_ctrl, pra_datapath and palette_region_allocator_unit.
package pra_pkg;

    localparam int REGION_COUNT_DEF = 64;
    localparam int CFG_DATA_W       = 64;
    localparam int CFG_IDX_W        = 3;
    localparam int CLS_W            = 7;
    localparam int OWNER_W          = 32;
    localparam int AGE_W            = 8;
    localparam int FUNC_W           = 2;
    localparam int REGION_W         = 6;

    localparam logic [AGE_W-1:0]   AGE_MAX     = 8'hff;
    localparam logic [OWNER_W-1:0] EMPTY_OWNER = 32'hffff_ffff;

    localparam logic [CFG_IDX_W-1:0] CFG_CLASS0_FIRST = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLASS0_END   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLASS1_FIRST = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLASS1_END   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLASS0_MASK  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CLASS1_MASK  = 3'd5;

    localparam logic [CLS_W-1:0]      CLASS0_FIRST_RST = 7'd0;
    localparam logic [CLS_W-1:0]      CLASS0_END_RST   = 7'd16;
    localparam logic [CLS_W-1:0]      CLASS1_FIRST_RST = 7'd16;
    localparam logic [CLS_W-1:0]      CLASS1_END_RST   = 7'h2f;
    localparam logic [CFG_DATA_W-1:0] CLASS0_MASK_RST  = 64'h0000_0000_0000_ffff;
    localparam logic [CFG_DATA_W-1:0] CLASS1_MASK_RST  = 64'h0000_7fff_ffff_0000;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ALLOC = 2'd0,
        FUNC_TOUCH = 2'd1,
        FUNC_LOCK  = 2'd2,
        FUNC_FREE  = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SWEEP,
        ST_SELECT,
        ST_COMMIT,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic capture;
        logic init;
        logic sweep;
        logic select;
        logic commit;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic is_alloc;
        logic is_touch;
        logic nonempty;
        logic sweep_done;
        logic out_free;
    } status_t;

endpackage

// File: src/pra_ctrl.sv
// pra_ctrl: sequencing state machine of the palette region allocator.
// Depends on pra_pkg; drives pra_datapath through cmd_t, reads status_t.
module pra_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pra_pkg::status_t  status,
    output pra_pkg::cmd_t     cmd
);

    pra_pkg::state_t state_reg;
    pra_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pra_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pra_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = pra_pkg::ST_START;
                end
            end
            pra_pkg::ST_START: begin
                if ((status.is_alloc || status.is_touch) && status.nonempty) begin
                    state_next = pra_pkg::ST_SWEEP;
                end else begin
                    state_next = pra_pkg::ST_COMMIT;
                end
            end
            pra_pkg::ST_SWEEP: begin
                if (status.sweep_done) begin
                    state_next = status.is_alloc ? pra_pkg::ST_SELECT : pra_pkg::ST_COMMIT;
                end
            end
            pra_pkg::ST_SELECT: state_next = pra_pkg::ST_COMMIT;
            pra_pkg::ST_COMMIT: state_next = pra_pkg::ST_RESULT;
            pra_pkg::ST_RESULT: begin
                if (status.out_free) begin
                    state_next = pra_pkg::ST_IDLE;
                end
            end
            default: state_next = pra_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            pra_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            pra_pkg::ST_START:  cmd.init   = 1'b1;
            pra_pkg::ST_SWEEP:  cmd.sweep  = 1'b1;
            pra_pkg::ST_SELECT: cmd.select = 1'b1;
            pra_pkg::ST_COMMIT: cmd.commit = 1'b1;
            pra_pkg::ST_RESULT: cmd.load_out = status.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

// File: src/pra_datapath.sv
// pra_datapath: class registers, age and owner memories, region bit vectors,
// sweep trackers and the result register. Depends on pra_pkg; driven by pra_ctrl.
module pra_datapath #(
    parameter int REGION_COUNT = pra_pkg::REGION_COUNT_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [pra_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [pra_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic [pra_pkg::FUNC_W-1:0]         s_func,
    input  logic                               s_size_class,
    input  logic [pra_pkg::OWNER_W-1:0]        s_owner_handle,
    input  logic [pra_pkg::REGION_W-1:0]       s_region_index,
    input  pra_pkg::cmd_t                      cmd,
    output pra_pkg::status_t                   status,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [pra_pkg::REGION_W-1:0]       m_granted_region,
    output logic                               m_evicted,
    output logic [pra_pkg::OWNER_W-1:0]        m_evicted_owner
);

    localparam int IW = $clog2(REGION_COUNT);
    localparam int CW = IW + 1;
    localparam logic [pra_pkg::CLS_W-1:0] RC_CLS = pra_pkg::CLS_W'(REGION_COUNT);
    localparam logic [pra_pkg::REGION_W:0] RC_IDX = (pra_pkg::REGION_W + 1)'(REGION_COUNT);

    // class registers
    logic [pra_pkg::CLS_W-1:0]      class0_first_reg, class0_end_reg;
    logic [pra_pkg::CLS_W-1:0]      class1_first_reg, class1_end_reg;
    logic [pra_pkg::CFG_DATA_W-1:0] class0_mask_reg, class1_mask_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            class0_first_reg <= pra_pkg::CLASS0_FIRST_RST;
            class0_end_reg   <= pra_pkg::CLASS0_END_RST;
            class1_first_reg <= pra_pkg::CLASS1_FIRST_RST;
            class1_end_reg   <= pra_pkg::CLASS1_END_RST;
            class0_mask_reg  <= pra_pkg::CLASS0_MASK_RST;
            class1_mask_reg  <= pra_pkg::CLASS1_MASK_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                pra_pkg::CFG_CLASS0_FIRST: class0_first_reg <= cfg_wdata[pra_pkg::CLS_W-1:0];
                pra_pkg::CFG_CLASS0_END:   class0_end_reg   <= cfg_wdata[pra_pkg::CLS_W-1:0];
                pra_pkg::CFG_CLASS1_FIRST: class1_first_reg <= cfg_wdata[pra_pkg::CLS_W-1:0];
                pra_pkg::CFG_CLASS1_END:   class1_end_reg   <= cfg_wdata[pra_pkg::CLS_W-1:0];
                pra_pkg::CFG_CLASS0_MASK:  class0_mask_reg  <= cfg_wdata;
                pra_pkg::CFG_CLASS1_MASK:  class1_mask_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // request capture, range clipped to the region count
    pra_pkg::func_t                 func_reg;
    logic [pra_pkg::OWNER_W-1:0]    owner_reg;
    logic [pra_pkg::REGION_W-1:0]   ridx_reg;
    logic [CW-1:0]                  lo_reg, hi_reg;
    logic [pra_pkg::CFG_DATA_W-1:0] mask_reg;
    logic [pra_pkg::CLS_W-1:0]      lo_raw, hi_raw, lo_clip, hi_clip;

    always_comb begin
        lo_raw  = s_size_class ? class1_first_reg : class0_first_reg;
        hi_raw  = s_size_class ? class1_end_reg : class0_end_reg;
        lo_clip = (lo_raw > RC_CLS) ? RC_CLS : lo_raw;
        hi_clip = (hi_raw > RC_CLS) ? RC_CLS : hi_raw;
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            func_reg  <= pra_pkg::func_t'(s_func);
            owner_reg <= s_owner_handle;
            ridx_reg  <= s_region_index;
            lo_reg    <= lo_clip[CW-1:0];
            hi_reg    <= hi_clip[CW-1:0];
            mask_reg  <= s_size_class ? class1_mask_reg : class0_mask_reg;
        end
    end

    logic nonempty, in_range, is_alloc, is_touch, alloc_grant;
    assign nonempty    = lo_reg < hi_reg;
    assign in_range    = {1'b0, ridx_reg} < RC_IDX;
    assign is_alloc    = func_reg == pra_pkg::FUNC_ALLOC;
    assign is_touch    = func_reg == pra_pkg::FUNC_TOUCH;
    assign alloc_grant = is_alloc && nonempty;

    // age memory with per-entry valid bits; an unwritten entry reads as zero
    logic [pra_pkg::AGE_W-1:0] age_mem [REGION_COUNT];
    logic [REGION_COUNT-1:0]   age_vld_reg;
    logic [pra_pkg::AGE_W-1:0] age_rd_reg;
    logic                      age_rd_vld_reg;
    logic                      age_we;
    logic [IW-1:0]             age_wa;
    logic [pra_pkg::AGE_W-1:0] age_wd;
    logic [IW-1:0]             pick_sel, pick_reg;

    // sweep pipeline
    logic [CW-1:0] rd_idx_reg;
    logic          rd_pend_reg;
    logic [IW-1:0] rd_addr_d_reg;
    logic          issue;
    logic [pra_pkg::AGE_W-1:0] age_cur, aged;

    assign issue   = cmd.sweep && (rd_idx_reg < hi_reg);
    assign age_cur = age_rd_vld_reg ? age_rd_reg : '0;
    assign aged    = (age_cur == pra_pkg::AGE_MAX) ? pra_pkg::AGE_MAX
                                                   : age_cur + pra_pkg::AGE_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_pend_reg <= 1'b0;
        end else if (cmd.init) begin
            rd_pend_reg <= 1'b0;
        end else if (cmd.sweep) begin
            rd_pend_reg <= issue;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.init) begin
            rd_idx_reg <= lo_reg;
        end else if (issue) begin
            rd_idx_reg    <= rd_idx_reg + CW'(1);
            rd_addr_d_reg <= rd_idx_reg[IW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            age_rd_reg     <= age_mem[rd_idx_reg[IW-1:0]];
            age_rd_vld_reg <= age_vld_reg[rd_idx_reg[IW-1:0]];
        end
        if (age_we) begin
            age_mem[age_wa] <= age_wd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            age_vld_reg <= '0;
        end else if (age_we) begin
            age_vld_reg[age_wa] <= 1'b1;
        end
    end

    always_comb begin
        age_we = (cmd.sweep && rd_pend_reg)
              || (cmd.commit && (alloc_grant || (is_touch && in_range)));
        if (cmd.sweep) begin
            age_wa = rd_addr_d_reg;
            age_wd = aged;
        end else begin
            age_wa = is_alloc ? pick_reg : ridx_reg[IW-1:0];
            age_wd = '0;
        end
    end

    // region bits
    logic [REGION_COUNT-1:0] resident_reg, lock_reg;

    // first free and oldest unlocked trackers
    logic                      free_found_reg, vic_found_reg;
    logic [IW-1:0]             free_idx_reg, vic_idx_reg;
    logic [pra_pkg::AGE_W-1:0] vic_age_reg;

    always_ff @(posedge aclk) begin
        if (cmd.init) begin
            free_found_reg <= 1'b0;
            vic_found_reg  <= 1'b0;
            vic_idx_reg    <= lo_reg[IW-1:0];
        end else if (cmd.sweep && rd_pend_reg) begin
            if (!resident_reg[rd_addr_d_reg] && !free_found_reg) begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= rd_addr_d_reg;
            end
            if (!lock_reg[rd_addr_d_reg] && (!vic_found_reg || aged > vic_age_reg)) begin
                vic_found_reg <= 1'b1;
                vic_age_reg   <= aged;
                vic_idx_reg   <= rd_addr_d_reg;
            end
        end
    end

    // victim selection and owner read
    logic [pra_pkg::CFG_DATA_W-1:0] res_wide;
    logic                           mask_full;
    logic                           evict_reg;
    logic [pra_pkg::OWNER_W-1:0]    owner_mem [REGION_COUNT];
    logic [pra_pkg::OWNER_W-1:0]    owner_rd_reg;

    always_comb begin
        res_wide = '0;
        for (int i = 0; i < REGION_COUNT; i++) begin
            res_wide[i] = resident_reg[i];
        end
        mask_full = (mask_reg & res_wide) == mask_reg;
        pick_sel  = (!mask_full && free_found_reg) ? free_idx_reg : vic_idx_reg;
    end

    always_ff @(posedge aclk) begin
        if (cmd.select) begin
            pick_reg     <= pick_sel;
            evict_reg    <= resident_reg[pick_sel];
            owner_rd_reg <= owner_mem[pick_sel];
        end
        if (cmd.commit && alloc_grant) begin
            owner_mem[pick_reg] <= owner_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            resident_reg <= '0;
            lock_reg     <= '0;
        end else if (cmd.commit) begin
            if (alloc_grant) begin
                resident_reg[pick_reg] <= 1'b1;
            end else if (in_range && func_reg == pra_pkg::FUNC_LOCK) begin
                lock_reg[ridx_reg[IW-1:0]] <= 1'b1;
            end else if (in_range && func_reg == pra_pkg::FUNC_FREE) begin
                resident_reg[ridx_reg[IW-1:0]] <= 1'b0;
                lock_reg[ridx_reg[IW-1:0]]     <= 1'b0;
            end
        end
    end

    // result word
    logic [pra_pkg::REGION_W-1:0] res_granted_reg;
    logic                         res_evicted_reg;
    logic [pra_pkg::OWNER_W-1:0]  res_owner_reg;

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            if (is_alloc) begin
                res_granted_reg <= nonempty ? pra_pkg::REGION_W'(pick_reg) : '0;
                res_evicted_reg <= alloc_grant && evict_reg;
                res_owner_reg   <= (alloc_grant && evict_reg) ? owner_rd_reg
                                                              : pra_pkg::EMPTY_OWNER;
            end else begin
                res_granted_reg <= ridx_reg;
                res_evicted_reg <= 1'b0;
                res_owner_reg   <= pra_pkg::EMPTY_OWNER;
            end
        end
    end

    logic                         m_valid_reg;
    logic [pra_pkg::REGION_W-1:0] m_granted_reg;
    logic                         m_evicted_reg;
    logic [pra_pkg::OWNER_W-1:0]  m_owner_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_granted_reg <= res_granted_reg;
            m_evicted_reg <= res_evicted_reg;
            m_owner_reg   <= res_owner_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_granted_region = m_granted_reg;
    assign m_evicted        = m_evicted_reg;
    assign m_evicted_owner  = m_owner_reg;

    always_comb begin
        status.is_alloc   = is_alloc;
        status.is_touch   = is_touch;
        status.nonempty   = nonempty;
        status.sweep_done = (rd_idx_reg == hi_reg) && !rd_pend_reg;
        status.out_free   = !m_valid_reg || m_ready;
    end

    a_sweep_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.sweep |-> (rd_idx_reg <= hi_reg))
        else $error("sweep index ran past class end");

    a_select_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.select |-> (is_alloc && nonempty))
        else $error("victim selection on empty class or non-allocate");

    a_grant_resident: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && alloc_grant) |=> resident_reg[pick_reg])
        else $error("granted region not resident after allocate");

    a_no_evict_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_evicted_reg) |-> (m_owner_reg == pra_pkg::EMPTY_OWNER))
        else $error("owner reported without eviction");

endmodule

// File: src/palette_region_allocator_unit.sv
// palette_region_allocator_unit: top level of the palette region allocator.
// Depends on pra_pkg, pra_ctrl and pra_datapath.
//
// Usage:
//   Input words (s_valid/s_ready) carry func, size_class, owner_handle and
//   region_index; each produces exactly one result word on m_valid/m_ready
//   (granted_region, evicted, evicted_owner).
//   Class ranges and eviction masks are written through cfg_we/cfg_addr/
//   cfg_wdata, one register per cycle; the user must write them only while
//   the unit is idle, as the block itself does not enforce this. One word is
//   processed at a time. Allocate and touch sweep the class range through
//   the age memory, one region per cycle.
//   Lock, free and operations on an empty class skip the sweep. The next word
//   can be taken in the same cycle as the first possible result handshake.
//   The sweep through the age memory does one read and one write per cycle.
//   Reset (aresetn low, synchronous) clears the resident, lock and age-valid
//   bits and loads the default class registers; no clearing pass is needed.
//   When the receiver stalls, the result is held in the output register; one
//   more word may be taken and processed, and its result waits until the
//   output register is free.
module palette_region_allocator_unit #(
    parameter int REGION_COUNT = pra_pkg::REGION_COUNT_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [pra_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [pra_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [pra_pkg::FUNC_W-1:0]     s_func,
    input  logic                           s_size_class,
    input  logic [pra_pkg::OWNER_W-1:0]    s_owner_handle,
    input  logic [pra_pkg::REGION_W-1:0]   s_region_index,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [pra_pkg::REGION_W-1:0]   m_granted_region,
    output logic                           m_evicted,
    output logic [pra_pkg::OWNER_W-1:0]    m_evicted_owner
);

    pra_pkg::cmd_t    cmd;
    pra_pkg::status_t status;

    pra_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    pra_datapath #(
        .REGION_COUNT (REGION_COUNT)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .s_func           (s_func),
        .s_size_class     (s_size_class),
        .s_owner_handle   (s_owner_handle),
        .s_region_index   (s_region_index),
        .cmd              (cmd),
        .status           (status),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_granted_region (m_granted_region),
        .m_evicted        (m_evicted),
        .m_evicted_owner  (m_evicted_owner)
    );

endmodule
